/* src/bmd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the block mean downsampler.
// Depends on nothing; bmd_fifo, bmd_front, bmd_back, the top and the testbench import it.
package bmd_pkg;

    localparam int OUT_CELLS_DEF  = 120;
    localparam int MAX_FACTOR_DEF = 30;
    localparam int QUEUE_DEPTH    = 4;
    localparam int ELEV_W         = 16;
    localparam int FACTOR_W       = 5;
    localparam int PCT_W          = 7;
    localparam int CELL_W         = 7;
    // Wide enough for any cell index while OUT_CELLS is at most 256.
    localparam int CELL_IDX_W     = 8;
    localparam int PCT_SCALE      = 200;

    localparam logic [FACTOR_W-1:0]      FACTOR_RESET = 5'd30;
    localparam logic signed [ELEV_W-1:0] VOID_SAMPLE  = 16'sh8000;

    typedef struct packed {
        logic signed [ELEV_W-1:0] elevation;
        logic                     tile_first;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEV_W-1:0] mean_value;
        logic [PCT_W-1:0]         land_percent;
        logic [CELL_W-1:0]        cell_row;
        logic [CELL_W-1:0]        cell_col;
        logic                     tile_last;
    } t_out_item;

    typedef struct packed {
        logic [FACTOR_W-1:0] block_factor;
    } t_cfg_item;

    // One classified sample on its way from the front to the back end.
    typedef struct packed {
        logic [CELL_IDX_W-1:0]    col;
        logic [CELL_IDX_W-1:0]    row;
        logic                     first;
        logic                     done;
        logic                     last;
        logic signed [ELEV_W-1:0] contrib;
        logic                     land;
    } t_entry;

    typedef enum logic [1:0] {
        FR_RUN,
        FR_SETUP,
        FR_REMAP
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACC,
        BK_DIV
    } t_back_state;

endpackage

/* src/bmd_chan_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload of a chosen type.
// Depends on nothing; payload types come from bmd_pkg at instantiation.
interface bmd_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* src/bmd_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

/* src/bmd_fifo.sv */
`timescale 1ns / 1ps
// Short queue of classified samples between the front and the back end.
// Depends on bmd_pkg for the entry type.
module bmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bmd_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output bmd_pkg::t_entry o_entry,
    output logic            o_empty
);
    import bmd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif
endmodule

/* src/bmd_front.sv */
`timescale 1ns / 1ps
// Front end: holds the factor register and the raster position counters,
// classifies each sample and pushes it into the queue. Depends on bmd_pkg and bmd_chan_if.
module bmd_front #(
    parameter int OUT_CELLS  = bmd_pkg::OUT_CELLS_DEF,
    parameter int MAX_FACTOR = bmd_pkg::MAX_FACTOR_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bmd_chan_if.sink                            i_in,
    bmd_chan_if.sink                            i_cfg,
    output logic                                o_push,
    output bmd_pkg::t_entry                     o_entry,
    input  logic                                i_full,
    output logic [$clog2(MAX_FACTOR + 1)-1:0]   o_factor
);
    import bmd_pkg::*;

    localparam int F_W    = $clog2(MAX_FACTOR + 1);
    localparam int CW     = (OUT_CELLS > 1) ? $clog2(OUT_CELLS) : 1;
    localparam int SCOL_W = $clog2(MAX_FACTOR * OUT_CELLS + 1) + 1;
    localparam int CNT_W  = $clog2(SCOL_W + 1);

    function automatic logic [F_W-1:0] eff_factor(input logic [FACTOR_W-1:0] v);
        logic [F_W-1:0] f;
        if (v == '0) begin
            f = F_W'(1);
        end else if (int'(v) > MAX_FACTOR) begin
            f = F_W'(MAX_FACTOR);
        end else begin
            f = F_W'(v);
        end
        return f;
    endfunction

    t_front_state      r_state, n_state;
    logic [F_W-1:0]    r_f, n_f;
    logic [SCOL_W-1:0] r_scol, n_scol;
    logic [CW-1:0]     r_col, n_col;
    logic [F_W-1:0]    r_q, n_q;
    logic [F_W-1:0]    r_row, n_row;
    logic [CW-1:0]     r_brow, n_brow;
    logic [SCOL_W-1:0] r_dq, n_dq;
    logic [F_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic [CW-1:0]     cur_col, cur_brow;
    logic [F_W-1:0]    cur_q, cur_row, f_last;
    logic              q_last, r_last, col_last, brow_last, accept;
    logic [SCOL_W-1:0] side, scol_clamped;
    logic [F_W:0]      trial;
    logic              ge;

    assign o_factor    = r_f;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == FR_RUN) && !i_full && !i_cfg.valid;
    assign accept      = i_in.valid && i_in.ready;
    assign o_push      = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_RUN;
            r_f     <= eff_factor(FACTOR_RESET);
            r_scol  <= '0;
            r_col   <= '0;
            r_q     <= '0;
            r_row   <= '0;
            r_brow  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_f     <= n_f;
            r_scol  <= n_scol;
            r_col   <= n_col;
            r_q     <= n_q;
            r_row   <= n_row;
            r_brow  <= n_brow;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq  <= n_dq;
        r_rem <= n_rem;
    end

    always_comb begin
        n_state = r_state;
        n_f     = r_f;
        n_scol  = r_scol;
        n_col   = r_col;
        n_q     = r_q;
        n_row   = r_row;
        n_brow  = r_brow;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_cnt   = r_cnt;

        // A tile start restarts every position counter before the sample is placed.
        cur_col   = i_in.payload.tile_first ? '0 : r_col;
        cur_q     = i_in.payload.tile_first ? '0 : r_q;
        cur_row   = i_in.payload.tile_first ? '0 : r_row;
        cur_brow  = i_in.payload.tile_first ? '0 : r_brow;
        f_last    = F_W'(r_f - 1'b1);
        q_last    = (cur_q == f_last);
        r_last    = (cur_row == f_last);
        col_last  = (cur_col == CW'(OUT_CELLS - 1));
        brow_last = (cur_brow == CW'(OUT_CELLS - 1));

        o_entry.col     = CELL_IDX_W'(cur_col);
        o_entry.row     = CELL_IDX_W'(cur_brow);
        o_entry.first   = (cur_row == '0) && (cur_q == '0);
        o_entry.done    = r_last && q_last;
        o_entry.last    = brow_last && col_last;
        o_entry.contrib = (i_in.payload.elevation == VOID_SAMPLE) ? '0
                                                                  : i_in.payload.elevation;
        o_entry.land    = (i_in.payload.elevation != '0);

        side         = SCOL_W'(r_f * OUT_CELLS);
        scol_clamped = (r_scol >= side) ? '0 : r_scol;
        trial        = {r_rem, r_dq[SCOL_W-1]};
        ge           = (trial >= {1'b0, r_f});

        case (r_state)
            FR_RUN: begin
                if (accept) begin
                    if (q_last) begin
                        n_q = '0;
                        if (col_last) begin
                            n_col  = '0;
                            n_scol = '0;
                            if (r_last) begin
                                n_row  = '0;
                                n_brow = brow_last ? '0 : cur_brow + 1'b1;
                            end else begin
                                n_row  = cur_row + 1'b1;
                                n_brow = cur_brow;
                            end
                        end else begin
                            n_col  = cur_col + 1'b1;
                            n_scol = (i_in.payload.tile_first ? '0 : r_scol) + 1'b1;
                            n_row  = cur_row;
                            n_brow = cur_brow;
                        end
                    end else begin
                        n_q    = cur_q + 1'b1;
                        n_col  = cur_col;
                        n_scol = (i_in.payload.tile_first ? '0 : r_scol) + 1'b1;
                        n_row  = cur_row;
                        n_brow = cur_brow;
                    end
                end
            end
            FR_SETUP: begin
                // Positions outside the new tile geometry restart at zero.
                n_scol  = scol_clamped;
                n_row   = (r_row >= r_f) ? '0 : r_row;
                n_dq    = scol_clamped;
                n_rem   = '0;
                n_cnt   = CNT_W'(SCOL_W);
                n_state = FR_REMAP;
            end
            FR_REMAP: begin
                // One restoring division step a cycle: column and offset of sample_col.
                n_rem = F_W'(ge ? trial - {1'b0, r_f} : trial);
                n_dq  = {r_dq[SCOL_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_col   = n_dq[CW-1:0];
                    n_q     = n_rem;
                    n_state = FR_RUN;
                end
            end
            default: begin
                n_state = FR_RUN;
            end
        endcase

        if (i_cfg.valid) begin
            n_f     = eff_factor(i_cfg.payload.block_factor);
            n_state = FR_SETUP;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_in_remap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != FR_RUN |-> !o_push) else $error("sample taken during remap");
    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == FR_RUN |-> (r_q < r_f) && (r_row < r_f))
        else $error("position counter beyond factor");
    a_single_sample_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_entry.done |-> (o_entry.first == (r_f == F_W'(1))))
        else $error("block start and end disagree with factor");
`endif
endmodule

/* src/bmd_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module bmd_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_dq;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial  = {r_rem, r_dq[NUM_W-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quo  = r_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_dq  <= i_num;
        end else if (r_busy) begin
            r_rem <= DEN_W'(ge ? trial - {1'b0, r_den} : trial);
            r_dq  <= {r_dq[NUM_W-2:0], ge};
        end
    end
endmodule

/* src/bmd_back.sv */
`timescale 1ns / 1ps
// Back end: per-column accumulation in RAM, rounding divisions and the
// output register. Depends on bmd_pkg, bmd_chan_if, bmd_ram and bmd_div.
module bmd_back #(
    parameter int OUT_CELLS  = bmd_pkg::OUT_CELLS_DEF,
    parameter int MAX_FACTOR = bmd_pkg::MAX_FACTOR_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  bmd_pkg::t_entry                   i_entry,
    output logic                              o_pop,
    input  logic [$clog2(MAX_FACTOR + 1)-1:0] i_factor,
    bmd_chan_if.source                        o_out
);
    import bmd_pkg::*;

    localparam int F_W    = $clog2(MAX_FACTOR + 1);
    localparam int CW     = (OUT_CELLS > 1) ? $clog2(OUT_CELLS) : 1;
    localparam int N_W    = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int SUM_W  = ELEV_W + N_W + 1;
    localparam int LAND_W = N_W;
    localparam int MNUM_W = SUM_W + 1;
    localparam int DEN_W  = N_W + 1;
    localparam int LNUM_W = $clog2((PCT_SCALE + 1) * MAX_FACTOR * MAX_FACTOR + 1);

    t_back_state             r_state, n_state;
    t_entry                  r_entry;
    logic [OUT_CELLS-1:0]    r_valid;
    logic [N_W-1:0]          r_n;
    logic                    r_neg;
    t_out_item               r_out;
    logic                    r_out_valid;

    logic [CW-1:0]             addr;
    logic [SUM_W+LAND_W-1:0]   rdata, wdata;
    logic                      we, hit, load;
    logic signed [SUM_W-1:0]   old_sum, new_sum;
    logic [LAND_W-1:0]         old_land, new_land;
    logic [SUM_W-1:0]          mag;
    logic [MNUM_W-1:0]         m_num;
    logic [LNUM_W-1:0]         l_num;
    logic [DEN_W-1:0]          den;
    logic                      start, m_done, l_done;
    logic [MNUM_W-1:0]         m_quo;
    logic [LNUM_W-1:0]         l_quo;

    bmd_ram #(
        .WIDTH (SUM_W + LAND_W),
        .DEPTH (OUT_CELLS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (o_pop),
        .i_raddr (i_entry.col[CW-1:0]),
        .o_rdata (rdata)
    );

    bmd_div #(.NUM_W(MNUM_W), .DEN_W(DEN_W)) u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_num   (m_num),
        .i_den   (den),
        .o_done  (m_done),
        .o_quo   (m_quo)
    );

    bmd_div #(.NUM_W(LNUM_W), .DEN_W(DEN_W)) u_land_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_num   (l_num),
        .i_den   (den),
        .o_done  (l_done),
        .o_quo   (l_quo)
    );

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        we      = 1'b0;
        start   = 1'b0;
        load    = 1'b0;

        addr = r_entry.col[CW-1:0];
        // A block's first sample in a column overwrites; unwritten entries read as zero.
        hit      = r_valid[addr] && !r_entry.first;
        old_sum  = hit ? rdata[SUM_W+LAND_W-1:LAND_W] : '0;
        old_land = hit ? rdata[LAND_W-1:0] : '0;
        new_sum  = old_sum + SUM_W'(r_entry.contrib);
        new_land = old_land + LAND_W'(r_entry.land);
        wdata    = {new_sum, new_land};

        // Rounded quotients: (2|s| + n) / 2n and (200 l + n) / 2n.
        mag   = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
        m_num = {mag, 1'b0} + MNUM_W'(r_n);
        l_num = LNUM_W'(LNUM_W'(new_land) * LNUM_W'(PCT_SCALE)) + LNUM_W'(r_n);
        den   = {r_n, 1'b0};

        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_ACC;
                end
            end
            BK_ACC: begin
                we = 1'b1;
                if (r_entry.done) begin
                    start   = 1'b1;
                    n_state = BK_DIV;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_DIV: begin
                if (m_done && l_done && (!r_out_valid || o_out.ready)) begin
                    load    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) begin
                r_valid[addr] <= 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= N_W'(i_factor * i_factor);
        if (o_pop) begin
            r_entry <= i_entry;
        end
        if (start) begin
            r_neg <= new_sum[SUM_W-1];
        end
        if (load) begin
            r_out.mean_value   <= r_neg ? -m_quo[ELEV_W-1:0] : m_quo[ELEV_W-1:0];
            r_out.land_percent <= l_quo[PCT_W-1:0];
            r_out.cell_row     <= r_entry.row[CELL_W-1:0];
            r_out.cell_col     <= r_entry.col[CELL_W-1:0];
            r_out.tile_last    <= r_entry.last;
        end
    end

`ifndef ASSERT_OFF
    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_ACC |-> $past(r_state) == BK_IDLE)
        else $error("accumulate without a RAM read");
    a_plain_sample_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_ACC && !r_entry.done |=> r_state == BK_IDLE)
        else $error("non-final sample did not return to idle");
    a_block_end_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_ACC && r_entry.done |=> r_state == BK_DIV && !m_done && !l_done)
        else $error("block end did not start the dividers");
`endif
endmodule

/* src/block_mean_downsampler.sv */
`timescale 1ns / 1ps
// Block mean downsampler: reduces each factor-by-factor block of a raster
// elevation tile to its rounded mean and land percentage.
//
// Channels: i_in takes samples (elevation, tile_first) in raster order;
// o_out gives one transaction per completed block (mean_value, land_percent,
// cell_row, cell_col, tile_last); i_cfg writes block_factor. The user must
// write block_factor only while idle; the block itself does not enforce it.
// A write is followed by a setup and a remap of the column counters during
// which i_in is not ready. The back end reads the accumulator RAM for each
// sample, then adds and writes it back, before it pops the next sample; a
// block's last sample also starts the mean and land dividers, and its result
// loads into the output register once both are done and that register is
// free. A four-entry queue lets the front keep accepting while the back end
// works. When the receiver stalls, the output register holds, the back end
// waits in its divide state and the queue fills until i_in drops ready.
// Reset clears the counters, the column valid bits and the output valid,
// and sets block_factor to 30; no clearing pass is needed.
// Depends on bmd_pkg, bmd_chan_if, bmd_fifo, bmd_front and bmd_back.
module block_mean_downsampler #(
    parameter int OUT_CELLS  = bmd_pkg::OUT_CELLS_DEF,
    parameter int MAX_FACTOR = bmd_pkg::MAX_FACTOR_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmd_chan_if.sink    i_in,
    bmd_chan_if.sink    i_cfg,
    bmd_chan_if.source  o_out
);
    import bmd_pkg::*;

    localparam int F_W = $clog2(MAX_FACTOR + 1);

    t_entry         push_entry, head_entry;
    logic           push, pop, full, empty;
    logic [F_W-1:0] factor;

    bmd_front #(
        .OUT_CELLS  (OUT_CELLS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .o_push   (push),
        .o_entry  (push_entry),
        .i_full   (full),
        .o_factor (factor)
    );

    bmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (empty)
    );

    bmd_back #(
        .OUT_CELLS  (OUT_CELLS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .i_factor (factor),
        .o_out    (o_out)
    );
endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of block_mean_downsampler: directed and random
// sample streams over several block factors, checked by a scoreboard class.
// Depends on bmd_pkg, bmd_chan_if and the block's RTL.
module testbench;
    import bmd_pkg::*;

    localparam int N_CELLS = 120;
    localparam int F_MAX = 30;
    localparam longint CYCLE_LIMIT = 3_000_000;

    class cell_scoreboard;
        int factor_reg;
        int col_sum [N_CELLS];
        int col_land [N_CELLS];
        int sample_col, row_in_blk, blk_row;
        t_out_item pending [$];
        int n_errors, n_cells, n_tile_last;

        function new();
            factor_reg = 30;
            sample_col = 0; row_in_blk = 0; blk_row = 0;
            n_errors = 0; n_cells = 0; n_tile_last = 0;
            foreach (col_sum[k]) begin
                col_sum[k] = 0;
                col_land[k] = 0;
            end
        endfunction

        function int eff_factor();
            if (factor_reg == 0) return 1;
            if (factor_reg > F_MAX) return F_MAX;
            return factor_reg;
        endfunction

        function void note_sample(t_in_item it);
            int f, side, col, q, contrib, n, mag, quo;
            logic [15:0] mean_bits;
            t_out_item res;
            f = eff_factor();
            side = f * N_CELLS;
            if (it.tile_first) begin
                sample_col = 0; row_in_blk = 0; blk_row = 0;
            end
            if (sample_col >= side) sample_col = 0;
            if (row_in_blk >= f) row_in_blk = 0;
            if (blk_row >= N_CELLS) blk_row = 0;
            col = sample_col / f;
            q = sample_col - col * f;
            contrib = (it.elevation == VOID_SAMPLE) ? 0 : int'(it.elevation);
            if (row_in_blk == 0 && q == 0) begin
                col_sum[col] = contrib;
                col_land[col] = (it.elevation != 0);
            end else begin
                col_sum[col] += contrib;
                col_land[col] += (it.elevation != 0);
            end
            if (row_in_blk == f - 1 && q == f - 1) begin
                n = f * f;
                mag = (col_sum[col] < 0) ? -col_sum[col] : col_sum[col];
                quo = (2 * mag + n) / (2 * n);
                if (col_sum[col] < 0) quo = -quo;
                mean_bits = quo[15:0];
                res.mean_value = mean_bits;
                res.land_percent = 7'((200 * col_land[col] + n) / (2 * n));
                res.cell_row = 7'(blk_row);
                res.cell_col = 7'(col);
                res.tile_last = (blk_row == N_CELLS - 1 && col == N_CELLS - 1);
                pending.push_back(res);
            end
            sample_col++;
            if (sample_col >= side) begin
                sample_col = 0;
                row_in_blk++;
                if (row_in_blk >= f) begin
                    row_in_blk = 0;
                    blk_row++;
                    if (blk_row >= N_CELLS) blk_row = 0;
                end
            end
        endfunction

        function void check_cell(t_out_item got);
            t_out_item exp_cell;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                n_errors++;
                return;
            end
            exp_cell = pending.pop_front();
            n_cells++;
            if (got.tile_last) n_tile_last++;
            if (got.mean_value !== exp_cell.mean_value)
                mismatch("mean_value", exp_cell.mean_value, got.mean_value);
            if (got.land_percent !== exp_cell.land_percent)
                mismatch("land_percent", exp_cell.land_percent, got.land_percent);
            if (got.cell_row !== exp_cell.cell_row)
                mismatch("cell_row", exp_cell.cell_row, got.cell_row);
            if (got.cell_col !== exp_cell.cell_col)
                mismatch("cell_col", exp_cell.cell_col, got.cell_col);
            if (got.tile_last !== exp_cell.tile_last)
                mismatch("tile_last", exp_cell.tile_last, got.tile_last);
        endfunction

        function void mismatch(string field, logic [15:0] e, logic [15:0] a);
            $display("%0t: %s expected %0h actual %0h", $time, field, e, a);
            n_errors++;
        endfunction
    endclass

    logic i_clk, i_rst_n;
    longint cycle_count;
    cell_scoreboard sb;
    bit sender_calm, receiver_calm, hold_receiver;
    int hold_cycles;
    int n_samples;

    bmd_chan_if #(.t_payload(t_in_item)) in_ch ();
    bmd_chan_if #(.t_payload(t_cfg_item)) cfg_ch ();
    bmd_chan_if #(.t_payload(t_out_item)) out_ch ();

    block_mean_downsampler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .i_cfg(cfg_ch.sink), .o_out(out_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout at %0t", $time);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_receiver && hold_cycles > 0) begin
                out_ch.ready <= 0;
                hold_cycles--;
            end else begin
                out_ch.ready <= receiver_calm || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_cell(out_ch.payload);
    end

    // Valid stays high between back-to-back samples; drain() drops it.
    task automatic send_sample(logic signed [15:0] elev, logic first);
        t_in_item it;
        while (!sender_calm && $urandom_range(99) < 6) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        it.elevation = elev;
        it.tile_first = first;
        in_ch.payload <= it;
        in_ch.valid <= 1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_sample(it);
        n_samples++;
        @(negedge i_clk);
    endtask

    // Waits for all expected cells, then for the back end to go quiet.
    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_factor(int f);
        t_cfg_item c;
        drain();
        c.block_factor = 5'(f);
        cfg_ch.payload <= c;
        cfg_ch.valid <= 1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.factor_reg = f & 31;
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    function automatic logic signed [15:0] rand_elev();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sd0;
            2: return 16'sh7fff;
            3: return 16'(int'($urandom_range(65535)));
            default: return 16'(int'($urandom_range(400)) - 200);
        endcase
    endfunction

    // Random samples with occasional tile restarts once the hold-off has begun.
    task automatic random_samples(int count);
        for (int k = 0; k < count; k++) begin
            receiver_calm = (k >= 200 && k < 280);
            if (k == 300) begin
                receiver_calm = 0;
                hold_cycles = 400;
                hold_receiver = 1;
            end
            if (k >= 200 && k < 260) sender_calm = 1;
            else sender_calm = 0;
            send_sample(rand_elev(), k >= 320 && $urandom_range(199) == 0);
        end
        hold_receiver = 0;
        receiver_calm = 0;
    endtask

    initial begin
        sb = new();
        n_samples = 0;
        sender_calm = 0; receiver_calm = 0; hold_receiver = 0; hold_cycles = 0;
        i_rst_n = 0;
        in_ch.valid = 0; in_ch.payload = '0;
        cfg_ch.valid = 0; cfg_ch.payload = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Factor 1: every sample is a cell; extremes and void.
        write_factor(1);
        send_sample(16'sh8000, 1);
        send_sample(16'sh7fff, 0);
        send_sample(16'sd0, 0);
        send_sample(-16'sd1, 0);
        send_sample(16'sd1, 0);
        // Factor zero acts as one.
        write_factor(0);
        send_sample(16'sh5555, 0);
        send_sample(-16'sh2aab, 0);
        // Factor 2: a block of opposite signs that sums to zero, then a mid-block restart.
        write_factor(2);
        send_sample(16'sd1, 1);
        send_sample(16'sd2, 0);
        for (int k = 0; k < 238; k++) send_sample(16'sd0, 0);
        send_sample(-16'sd1, 0);
        send_sample(-16'sd2, 0);
        send_sample(16'sd7, 1);
        // Factor above the maximum acts as the maximum.
        write_factor(31);
        for (int k = 0; k < 8; k++) send_sample(16'sh7fff, k == 0);

        // Random parts over several factors.
        write_factor(3);
        random_samples(250);
        write_factor(1);
        // Factor 1 crosses a block-row boundary of the tile.
        for (int k = 0; k < 150; k++)
            send_sample(rand_elev(), k == 0);
        write_factor(2);
        random_samples(450);
        write_factor(30);
        random_samples(200);
        write_factor(17);
        random_samples(100);

        drain();
        $display("Sent %0d samples; checked %0d cells, %0d marked tile_last.",
                 n_samples, sb.n_cells, sb.n_tile_last);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
